// File: src/triangle_key_hash_table_unit_defines.svh
// Assertion helpers for the triangle key hash table
`ifndef TRIANGLE_KEY_HASH_TABLE_UNIT_DEFINES_SVH
`define TRIANGLE_KEY_HASH_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define TKH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TKH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/tkh_pkg.sv
`timescale 1ns / 1ps
package tkh_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = ADDR_BITS + 1;
  localparam int VERTEX_BITS = 20;
  localparam int SUM_BITS    = VERTEX_BITS + 2;
  localparam int NUM_BITS    = 20;
  localparam int LABEL_BITS  = 16;
  localparam int MAX_LABELS  = 4;
  localparam int HASH_BITS   = VERTEX_BITS + 7;
  localparam int DIV_CNT_BITS = $clog2(HASH_BITS + 1);
  localparam int HASH_A      = 31;
  localparam int HASH_B      = 57;
  localparam int BUCKET_RESET = 1024;
  localparam int LIMIT_RESET  = 4096;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_SKIPPED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_FOUND    = 3'd3;
  localparam logic [2:0] ST_ABSENT   = 3'd4;
  localparam logic [2:0] ST_TAKEN    = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  localparam logic [2:0] REG_BUCKETS = 3'd0;
  localparam logic [2:0] REG_LIMIT   = 3'd1;
  localparam logic [2:0] REG_REFCNT  = 3'd2;
  localparam logic [2:0] REG_SEL0    = 3'd3;
  localparam logic [2:0] REG_SEL1    = 3'd4;
  localparam logic [2:0] REG_SEL2    = 3'd5;
  localparam logic [2:0] REG_SEL3    = 3'd6;

  typedef enum logic [3:0] {
    S_SWEEP_RST, S_SWEEP, S_IDLE, S_HASH, S_DIV, S_HWAIT, S_HEAD,
    S_WWAIT, S_WALK, S_NEW, S_FIN
  } state_t;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] mn;
    logic [VERTEX_BITS-1:0] mx;
    logic [SUM_BITS-1:0]    sum;
    logic [NUM_BITS-1:0]    num;
    logic                   taken;
    logic [ADDR_BITS-1:0]   nxt;
  } slot_t;

  typedef struct packed {
    logic       load;
    logic       count;
    logic       clr_init;
    logic       hash;
    logic       div_step;
    logic       addr_rem;
    logic       adv;
    logic       wr_head;
    logic       wr_link;
    logic       wr_new;
    logic       wr_taken;
    logic       clr_wr;
    logic       set_code;
    logic [2:0] code;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic div_done;
    logic clr_done;
    logic head_empty;
    logic match;
    logic next_zero;
    logic taken;
    logic steps_max;
    logic full;
    logic out_hold;
  } sts_t;

endpackage

// File: src/triangle_key_hash_table_unit.sv
// Insert and lookup: key hash, 27-step bucket modulo, then a walk along the bucket's chain.
// Label-skipped insert and unused action go straight to the result. Clear: slot memory sweep.
// One item in flight; the next word is taken while a result waits in the output register.
// Reset is synchronous; afterwards a sweep zeroes the whole slot memory with the
// input stalled. Configuration writes are taken every cycle.
`timescale 1ns / 1ps
module triangle_key_hash_table_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [2:0]                      cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [1:0]                      action,
  input  logic [tkh_pkg::VERTEX_BITS-1:0] vertex_a,
  input  logic [tkh_pkg::VERTEX_BITS-1:0] vertex_b,
  input  logic [tkh_pkg::VERTEX_BITS-1:0] vertex_c,
  input  logic [tkh_pkg::NUM_BITS-1:0]    tri_number,
  input  logic [tkh_pkg::LABEL_BITS-1:0]  tri_label,
  input  logic [tkh_pkg::VERTEX_BITS-1:0] key_min,
  input  logic [tkh_pkg::VERTEX_BITS-1:0] key_max,
  input  logic [tkh_pkg::SUM_BITS-1:0]    key_sum,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [2:0]                      status,
  output logic [tkh_pkg::NUM_BITS-1:0]    found_number,
  output logic [tkh_pkg::NUM_BITS-1:0]    inserted_count
);
  import tkh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tkh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .action     (action),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  tkh_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .action         (action),
    .vertex_a       (vertex_a),
    .vertex_b       (vertex_b),
    .vertex_c       (vertex_c),
    .tri_number     (tri_number),
    .tri_label      (tri_label),
    .key_min        (key_min),
    .key_max        (key_max),
    .key_sum        (key_sum),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .status         (status),
    .found_number   (found_number),
    .inserted_count (inserted_count),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// File: src/tkh_ctrl.sv
`timescale 1ns / 1ps
`include "triangle_key_hash_table_unit_defines.svh"
module tkh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [1:0]        action,
  output logic              item_stall,
  input  tkh_pkg::sts_t     sts,
  output tkh_pkg::cmd_t     cmd
);
  import tkh_pkg::*;

  state_t state, state_next;
  logic   is_ins;

  always_ff @(posedge clk) begin
    if (rst) state <= S_SWEEP_RST;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) is_ins <= (action == ACT_INSERT);
  end

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP_RST: if (sts.clr_done) state_next = S_IDLE;
      S_SWEEP:     if (sts.clr_done) state_next = S_FIN;
      S_IDLE: begin
        if (item_valid) begin
          unique case (action)
            ACT_INSERT: state_next = sts.hit ? S_HASH : S_FIN;
            ACT_LOOKUP: state_next = S_HASH;
            ACT_CLEAR:  state_next = S_SWEEP;
            default:    state_next = S_FIN;
          endcase
        end
      end
      S_HASH:  state_next = S_DIV;
      S_DIV:   if (sts.div_done) state_next = S_HWAIT;
      S_HWAIT: state_next = S_HEAD;
      S_WWAIT: state_next = S_WALK;
      S_HEAD, S_WALK: begin
        if (state == S_HEAD && sts.head_empty) state_next = S_FIN;
        else if (is_ins) begin
          if (!sts.steps_max && !sts.next_zero) state_next = S_WWAIT;
          else if (sts.full) state_next = S_FIN;
          else state_next = S_NEW;
        end else begin
          if (sts.steps_max || sts.match || sts.next_zero) state_next = S_FIN;
          else state_next = S_WWAIT;
        end
      end
      S_NEW:   state_next = S_FIN;
      S_FIN:   if (!sts.out_hold) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_SWEEP_RST: cmd.clr_wr = 1'b1;
      S_SWEEP:     cmd.clr_wr = 1'b1;
      S_IDLE: begin
        if (item_valid) begin
          cmd.load = 1'b1;
          cmd.set_code = 1'b1;
          unique case (action)
            ACT_INSERT: begin
              cmd.count = sts.hit;
              cmd.code  = ST_SKIPPED;
            end
            ACT_LOOKUP: cmd.code = ST_ABSENT;
            ACT_CLEAR: begin
              cmd.clr_init = 1'b1;
              cmd.code = ST_CLEARED;
            end
            default: cmd.code = ST_ABSENT;
          endcase
        end
      end
      S_HASH: cmd.hash = 1'b1;
      S_DIV: begin
        if (sts.div_done) cmd.addr_rem = 1'b1;
        else cmd.div_step = 1'b1;
      end
      S_HWAIT, S_WWAIT: ;
      S_HEAD, S_WALK: begin
        cmd.set_code = 1'b1;
        if (state == S_HEAD && sts.head_empty) begin
          if (is_ins) begin
            cmd.wr_head = 1'b1;
            cmd.code = ST_INSERTED;
          end else begin
            cmd.code = ST_ABSENT;
          end
        end else if (is_ins) begin
          if (!sts.steps_max && !sts.next_zero) cmd.adv = 1'b1;
          else if (sts.full) cmd.code = ST_FULL;
          else begin
            cmd.wr_link = 1'b1;
            cmd.code = ST_INSERTED;
          end
        end else begin
          if (sts.steps_max || sts.match || sts.next_zero) begin
            if (!sts.match) cmd.code = ST_ABSENT;
            else if (sts.taken) cmd.code = ST_TAKEN;
            else begin
              cmd.wr_taken = 1'b1;
              cmd.code = ST_FOUND;
            end
          end else begin
            cmd.adv = 1'b1;
          end
        end
      end
      S_NEW: cmd.wr_new = 1'b1;
      S_FIN: cmd.emit = !sts.out_hold;
      default: ;
    endcase
  end

  `TKH_ASSERT_IMP(a_one_write, clk, rst, 1'b1, $onehot0({cmd.wr_head, cmd.wr_link, cmd.wr_new, cmd.wr_taken, cmd.clr_wr}), "more than one slot write")
  `TKH_ASSERT_NXT(a_fin_leave, clk, rst, state == S_FIN && !sts.out_hold, state == S_IDLE, "result not handed off")
  `TKH_ASSERT_NXT(a_clear_go, clk, rst, state == S_IDLE && item_valid && action == ACT_CLEAR, state == S_SWEEP, "clear did not start sweep")
  `TKH_ASSERT_NXT(a_link_new, clk, rst, cmd.wr_link, state == S_NEW, "link without new slot")

endmodule

// File: src/tkh_datapath.sv
`timescale 1ns / 1ps
module tkh_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [2:0]                      cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic [1:0]                      action,
  input  logic [tkh_pkg::VERTEX_BITS-1:0] vertex_a,
  input  logic [tkh_pkg::VERTEX_BITS-1:0] vertex_b,
  input  logic [tkh_pkg::VERTEX_BITS-1:0] vertex_c,
  input  logic [tkh_pkg::NUM_BITS-1:0]    tri_number,
  input  logic [tkh_pkg::LABEL_BITS-1:0]  tri_label,
  input  logic [tkh_pkg::VERTEX_BITS-1:0] key_min,
  input  logic [tkh_pkg::VERTEX_BITS-1:0] key_max,
  input  logic [tkh_pkg::SUM_BITS-1:0]    key_sum,
  input  logic                            result_stall,
  output logic                            result_valid,
  output logic [2:0]                      status,
  output logic [tkh_pkg::NUM_BITS-1:0]    found_number,
  output logic [tkh_pkg::NUM_BITS-1:0]    inserted_count,
  input  tkh_pkg::cmd_t                   cmd,
  output tkh_pkg::sts_t                   sts
);
  import tkh_pkg::*;

  logic [11:0]           bucket_count;
  logic [12:0]           overflow_limit;
  logic [2:0]            ref_count;
  logic [LABEL_BITS-1:0] select_ref [MAX_LABELS];

  logic [CNT_BITS-1:0]    eff_b, eff_lim, nfs;
  logic [NUM_BITS-1:0]    counter;
  logic [VERTEX_BITS-1:0] kmn, kmx, vmn, vmx;
  logic [SUM_BITS-1:0]    ksum;
  logic [NUM_BITS-1:0]    ktri;
  logic [NUM_BITS-1:0]    fnum;
  logic [2:0]             code;
  logic [2:0]             n_lab;
  logic                   hit;

  logic [HASH_BITS-1:0]    quo;
  logic [CNT_BITS-1:0]     rem, div_b, trial;
  logic [DIV_CNT_BITS-1:0] div_cnt;

  logic [ADDR_BITS-1:0] slot, clr_addr, waddr;
  logic [CNT_BITS-1:0]  steps;
  slot_t                mem [TABLE_DEPTH];
  slot_t                rdata, wdata, entry;
  logic                 we;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count   <= 12'(BUCKET_RESET);
      overflow_limit <= 13'(LIMIT_RESET);
      ref_count      <= '0;
      for (int i = 0; i < MAX_LABELS; i++) select_ref[i] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BUCKETS: bucket_count   <= cfg_data[11:0];
        REG_LIMIT:   overflow_limit <= cfg_data[12:0];
        REG_REFCNT:  ref_count      <= cfg_data[2:0];
        REG_SEL0:    select_ref[0]  <= cfg_data;
        REG_SEL1:    select_ref[1]  <= cfg_data;
        REG_SEL2:    select_ref[2]  <= cfg_data;
        REG_SEL3:    select_ref[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_b   = (bucket_count == '0) ? CNT_BITS'(1) : CNT_BITS'(bucket_count);
  assign eff_lim = (overflow_limit > 13'(TABLE_DEPTH)) ? CNT_BITS'(TABLE_DEPTH)
                                                       : CNT_BITS'(overflow_limit);
  assign n_lab = (ref_count > 3'(MAX_LABELS)) ? 3'(MAX_LABELS) : ref_count;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < MAX_LABELS; i++)
      if (3'(i) < n_lab && select_ref[i] == tri_label) hit = 1'b1;
  end

  always_comb begin
    vmn = (vertex_a < vertex_b) ? vertex_a : vertex_b;
    if (vertex_c < vmn) vmn = vertex_c;
    vmx = (vertex_a > vertex_b) ? vertex_a : vertex_b;
    if (vertex_c > vmx) vmx = vertex_c;
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (action == ACT_INSERT) begin
        kmn  <= vmn;
        kmx  <= vmx;
        ksum <= SUM_BITS'(vertex_a) + SUM_BITS'(vertex_b) + SUM_BITS'(vertex_c);
      end else begin
        kmn  <= key_min;
        kmx  <= key_max;
        ksum <= key_sum;
      end
      ktri <= tri_number;
    end
    if (cmd.set_code) code <= cmd.code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nfs     <= CNT_BITS'(BUCKET_RESET);
      counter <= '0;
    end else begin
      if (cmd.clr_init) begin
        nfs     <= eff_b;
        counter <= '0;
      end else if (cmd.count) begin
        counter <= counter + 1'b1;
      end
      if (cmd.wr_new) nfs <= nfs + 1'b1;
    end
  end

  // bucket = hash mod eff_b, one quotient bit per cycle
  assign trial = {rem[ADDR_BITS-1:0], quo[HASH_BITS-1]};

  always_ff @(posedge clk) begin
    if (cmd.hash) begin
      quo     <= HASH_BITS'(kmn) * HASH_BITS'(HASH_A) + HASH_BITS'(kmx) * HASH_BITS'(HASH_B);
      rem     <= '0;
      div_b   <= eff_b;
      div_cnt <= DIV_CNT_BITS'(HASH_BITS);
    end else if (cmd.div_step) begin
      quo     <= {quo[HASH_BITS-2:0], 1'b0};
      rem     <= (trial >= div_b) ? trial - div_b : trial;
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // chain pointer
  always_ff @(posedge clk) begin
    if (cmd.addr_rem) begin
      slot  <= rem[ADDR_BITS-1:0];
      steps <= '0;
    end else if (cmd.adv) begin
      slot  <= rdata.nxt;
      steps <= steps + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr_wr) clr_addr <= clr_addr + 1'b1;
  end

  // slot memory
  assign entry = '{mn: kmn, mx: kmx, sum: ksum, num: ktri, taken: 1'b0, nxt: '0};

  always_comb begin
    we    = 1'b1;
    waddr = slot;
    wdata = rdata;
    if (cmd.clr_wr) begin
      waddr = clr_addr;
      wdata = '0;
    end else if (cmd.wr_head) begin
      wdata = entry;
    end else if (cmd.wr_link) begin
      wdata.nxt = nfs[ADDR_BITS-1:0];
    end else if (cmd.wr_new) begin
      waddr = nfs[ADDR_BITS-1:0];
      wdata = entry;
    end else if (cmd.wr_taken) begin
      wdata.taken = 1'b1;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[slot];
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.load) fnum <= '0;
    else if (cmd.wr_taken) fnum <= rdata.num;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status         <= code;
      found_number   <= fnum;
      inserted_count <= counter;
    end
  end

  assign sts.hit        = hit;
  assign sts.div_done   = (div_cnt == '0);
  assign sts.clr_done   = (clr_addr == '1);
  assign sts.head_empty = (rdata.mn == '0);
  assign sts.match      = (rdata.mn == kmn) && (rdata.mx == kmx) && (rdata.sum == ksum);
  assign sts.next_zero  = (rdata.nxt == '0);
  assign sts.taken      = rdata.taken;
  assign sts.steps_max  = (steps == CNT_BITS'(TABLE_DEPTH));
  assign sts.full       = (nfs >= eff_lim);
  assign sts.out_hold   = result_valid && result_stall;

endmodule

// File: tb/tkh_checker.sv
`timescale 1ns / 1ps
module tkh_checker
  import tkh_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   item_valid,
  input  logic                   item_stall,
  input  logic [1:0]             action,
  input  logic [VERTEX_BITS-1:0] vertex_a,
  input  logic [VERTEX_BITS-1:0] vertex_b,
  input  logic [VERTEX_BITS-1:0] vertex_c,
  input  logic [NUM_BITS-1:0]    tri_number,
  input  logic [LABEL_BITS-1:0]  tri_label,
  input  logic [VERTEX_BITS-1:0] key_min,
  input  logic [VERTEX_BITS-1:0] key_max,
  input  logic [SUM_BITS-1:0]    key_sum,
  input  logic                   result_valid,
  input  logic                   result_stall,
  input  logic [2:0]             status,
  input  logic [NUM_BITS-1:0]    found_number,
  input  logic [NUM_BITS-1:0]    inserted_count,
  output int                     pending,
  output int                     errors
);

  typedef struct packed {
    logic [2:0]          st;
    logic [NUM_BITS-1:0] num;
    logic [NUM_BITS-1:0] cnt;
  } answer_t;

  logic [VERTEX_BITS-1:0] slot_mn   [TABLE_DEPTH];
  logic [VERTEX_BITS-1:0] slot_mx   [TABLE_DEPTH];
  logic [SUM_BITS-1:0]    slot_sum  [TABLE_DEPTH];
  logic [NUM_BITS-1:0]    slot_tri  [TABLE_DEPTH];
  logic                   slot_took [TABLE_DEPTH];
  logic [ADDR_BITS-1:0]   slot_nxt  [TABLE_DEPTH];

  int unsigned           buckets_reg, limit_reg, refs_reg;
  logic [LABEL_BITS-1:0] sel_reg [MAX_LABELS];
  int unsigned           free_slot;
  logic [NUM_BITS-1:0]   match_cnt;
  answer_t               answer_q[$];
  int                    err_cnt = 0;

  initial begin
    pending = 0;
    errors  = 0;
  end

  function automatic int unsigned eff_buckets();
    int unsigned b;
    b = buckets_reg;
    if (b == 0) b = 1;
    if (b > TABLE_DEPTH) b = TABLE_DEPTH;
    return b;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_mn[i] = '0; slot_mx[i] = '0; slot_sum[i] = '0;
      slot_tri[i] = '0; slot_took[i] = 1'b0; slot_nxt[i] = '0;
    end
    free_slot = eff_buckets();
    match_cnt = '0;
  endfunction

  function automatic int unsigned bucket_of(int unsigned mn, int unsigned mx);
    longint unsigned h;
    h = longint'(HASH_A) * mn + longint'(HASH_B) * mx;
    return 32'(h % eff_buckets());
  endfunction

  function automatic void fill_slot(int unsigned s, logic [VERTEX_BITS-1:0] mn,
                                    logic [VERTEX_BITS-1:0] mx, logic [SUM_BITS-1:0] sm,
                                    logic [NUM_BITS-1:0] num);
    slot_mn[s] = mn; slot_mx[s] = mx; slot_sum[s] = sm;
    slot_tri[s] = num; slot_took[s] = 1'b0; slot_nxt[s] = '0;
  endfunction

  function automatic logic [2:0] store_triangle();
    logic [VERTEX_BITS-1:0] mn, mx;
    logic [SUM_BITS-1:0]    sm;
    int unsigned            s, lim, n;
    logic                   hit;
    hit = 1'b0;
    n = (refs_reg > MAX_LABELS) ? MAX_LABELS : refs_reg;
    for (int i = 0; i < MAX_LABELS; i++)
      if (i < n && sel_reg[i] == tri_label) hit = 1'b1;
    if (!hit) return ST_SKIPPED;
    match_cnt = match_cnt + 1'b1;
    mn = vertex_a < vertex_b ? vertex_a : vertex_b;
    if (vertex_c < mn) mn = vertex_c;
    mx = vertex_a > vertex_b ? vertex_a : vertex_b;
    if (vertex_c > mx) mx = vertex_c;
    sm = SUM_BITS'(vertex_a) + SUM_BITS'(vertex_b) + SUM_BITS'(vertex_c);
    s = bucket_of(32'(mn), 32'(mx));
    if (slot_mn[s] == 0) begin
      fill_slot(s, mn, mx, sm, tri_number);
      return ST_INSERTED;
    end
    for (int k = 0; k < TABLE_DEPTH && slot_nxt[s] != 0; k++) s = 32'(slot_nxt[s]);
    lim = (limit_reg > TABLE_DEPTH) ? TABLE_DEPTH : limit_reg;
    if (free_slot >= lim) return ST_FULL;
    slot_nxt[s] = ADDR_BITS'(free_slot);
    fill_slot(free_slot, mn, mx, sm, tri_number);
    free_slot++;
    return ST_INSERTED;
  endfunction

  function automatic answer_t take_triangle();
    answer_t     r;
    int unsigned s;
    logic        same;
    r = '{st: ST_ABSENT, num: '0, cnt: '0};
    s = bucket_of(32'(key_min), 32'(key_max));
    if (slot_mn[s] == 0) return r;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (slot_mn[s] == key_min && slot_mx[s] == key_max && slot_sum[s] == key_sum) break;
      if (slot_nxt[s] == 0) break;
      s = 32'(slot_nxt[s]);
    end
    same = slot_mn[s] == key_min && slot_mx[s] == key_max && slot_sum[s] == key_sum;
    if (!same) return r;
    if (slot_took[s]) begin
      r.st = ST_TAKEN;
      return r;
    end
    slot_took[s] = 1'b1;
    r.st = ST_FOUND;
    r.num = slot_tri[s];
    return r;
  endfunction

  function automatic answer_t predict_word();
    answer_t r;
    r = '{st: ST_ABSENT, num: '0, cnt: '0};
    case (action)
      ACT_INSERT: r.st = store_triangle();
      ACT_LOOKUP: r = take_triangle();
      ACT_CLEAR: begin
        wipe_table();
        r.st = ST_CLEARED;
      end
      default: r.st = ST_ABSENT;
    endcase
    r.cnt = match_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      buckets_reg = BUCKET_RESET;
      limit_reg = LIMIT_RESET;
      refs_reg = 0;
      for (int i = 0; i < MAX_LABELS; i++) sel_reg[i] = '0;
      wipe_table();
      answer_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected word status %0d number %0d count %0d", $time,
                   status, found_number, inserted_count);
          err_cnt++;
        end else begin
          want = answer_q.pop_front();
          if (status !== want.st) begin
            $display("%0t: status expected %0d got %0d", $time, want.st, status);
            err_cnt++;
          end
          if (found_number !== want.num) begin
            $display("%0t: found_number expected %0d got %0d", $time, want.num,
                     found_number);
            err_cnt++;
          end
          if (inserted_count !== want.cnt) begin
            $display("%0t: inserted_count expected %0d got %0d", $time, want.cnt,
                     inserted_count);
            err_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BUCKETS: buckets_reg = 32'(cfg_data[11:0]);
          REG_LIMIT:   limit_reg = 32'(cfg_data[12:0]);
          REG_REFCNT:  refs_reg = 32'(cfg_data[2:0]);
          REG_SEL0:    sel_reg[0] = cfg_data;
          REG_SEL1:    sel_reg[1] = cfg_data;
          REG_SEL2:    sel_reg[2] = cfg_data;
          REG_SEL3:    sel_reg[3] = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall) answer_q.push_back(predict_word());
    end
    pending <= answer_q.size();
    errors <= err_cnt;
  end

endmodule

// File: tb/tb_triangle_key_hash_table_unit.sv
`timescale 1ns / 1ps
module tb_triangle_key_hash_table_unit;
  import tkh_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [2:0]             cfg_index = '0;
  logic [15:0]            cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic [1:0]             action = '0;
  logic [VERTEX_BITS-1:0] vertex_a = '0, vertex_b = '0, vertex_c = '0;
  logic [NUM_BITS-1:0]    tri_number = '0;
  logic [LABEL_BITS-1:0]  tri_label = '0;
  logic [VERTEX_BITS-1:0] key_min = '0, key_max = '0;
  logic [SUM_BITS-1:0]    key_sum = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [2:0]             status;
  logic [NUM_BITS-1:0]    found_number, inserted_count;
  int                     pending, errors;

  int                     tx_idle = 36, rx_idle = 53, words_sent = 0;
  logic [LABEL_BITS-1:0]  sel_lbl [MAX_LABELS];
  int                     refs_used;
  logic [VERTEX_BITS-1:0] known_mn[$], known_mx[$];
  logic [SUM_BITS-1:0]    known_sum[$];

  triangle_key_hash_table_unit u_top (.*);

  tkh_checker u_checker (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk)
    result_stall <= !rst && ($urandom_range(99) < rx_idle);

  function automatic logic [VERTEX_BITS-1:0] rand_vertex();
    if ($urandom_range(3) == 0) return VERTEX_BITS'($urandom_range(1, 20'hFFFFF));
    return VERTEX_BITS'($urandom_range(1, 24));
  endfunction

  task automatic push_word(logic [1:0] act, logic [19:0] a, logic [19:0] b, logic [19:0] c,
                           logic [19:0] num, logic [15:0] lbl, logic [19:0] kmn,
                           logic [19:0] kmx, logic [21:0] ks);
    if (words_sent < 185) begin
      tx_idle = 36; rx_idle = 53;
    end else if (words_sent < 370) begin
      tx_idle = 53; rx_idle = 36;
    end else begin
      tx_idle = 0; rx_idle = 0;
    end
    while ($urandom_range(99) < tx_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    action <= act;
    vertex_a <= a; vertex_b <= b; vertex_c <= c;
    tri_number <= num; tri_label <= lbl;
    key_min <= kmn; key_max <= kmx; key_sum <= ks;
    item_valid <= 1'b1;
    @(negedge clk);
    while (item_stall) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  task automatic insert_tri(logic [19:0] a, logic [19:0] b, logic [19:0] c,
                            logic [19:0] num, logic [15:0] lbl);
    logic [19:0] mn, mx;
    mn = a < b ? a : b;
    if (c < mn) mn = c;
    mx = a > b ? a : b;
    if (c > mx) mx = c;
    known_mn.push_back(mn);
    known_mx.push_back(mx);
    known_sum.push_back(22'(a) + 22'(b) + 22'(c));
    push_word(ACT_INSERT, a, b, c, num, lbl, 20'($urandom), 20'($urandom), 22'($urandom));
  endtask

  task automatic lookup_tri(logic [19:0] kmn, logic [19:0] kmx, logic [21:0] ks);
    push_word(ACT_LOOKUP, 20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
              16'($urandom), kmn, kmx, ks);
  endtask

  task automatic clear_table();
    known_mn.delete(); known_mx.delete(); known_sum.delete();
    push_word(ACT_CLEAR, 20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
              16'($urandom), 20'($urandom), 20'($urandom), 22'($urandom));
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    while (item_stall) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_put(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic setup(int bc, int lim, int rc, logic [15:0] l0, logic [15:0] l1,
                       logic [15:0] l2, logic [15:0] l3, bit wipe);
    wait_idle();
    sel_lbl[0] = l0; sel_lbl[1] = l1; sel_lbl[2] = l2; sel_lbl[3] = l3;
    refs_used = rc;
    cfg_put(REG_BUCKETS, 16'(bc));
    cfg_put(REG_LIMIT, 16'(lim));
    cfg_put(REG_REFCNT, 16'(rc));
    cfg_put(REG_SEL0, l0);
    cfg_put(REG_SEL1, l1);
    cfg_put(REG_SEL2, l2);
    cfg_put(REG_SEL3, l3);
    cfg_valid <= 1'b0;
    if (wipe) clear_table();
  endtask

  task automatic random_words(int n);
    int          r, k;
    logic [15:0] lbl;
    logic [21:0] ks;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 2) begin
        clear_table();
      end else if (r < 57) begin
        if (refs_used > 0 && $urandom_range(9) < 8) lbl = sel_lbl[$urandom_range(refs_used - 1)];
        else lbl = 16'($urandom);
        insert_tri(rand_vertex(), rand_vertex(), rand_vertex(),
                   20'($urandom_range(1, 20'hFFFFF)), lbl);
      end else if (known_mn.size() > 0 && $urandom_range(9) < 7) begin
        k = $urandom_range(known_mn.size() - 1);
        ks = known_sum[k];
        if ($urandom_range(9) == 0) ks = ks + 1'b1;
        lookup_tri(known_mn[k], known_mx[k], ks);
      end else begin
        lookup_tri(rand_vertex(), rand_vertex(), 22'($urandom_range(3, 3145725)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    setup(16, 18, 4, 16'h0000, 16'hFFFF, 16'h1234, 16'hA5A5, 1'b1);
    insert_tri(20'd1, 20'd1, 20'd1, 20'd1, 16'h0000);
    insert_tri(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    insert_tri(20'd5, 20'd6, 20'd7, 20'd9, 16'h0007);
    insert_tri(20'd2, 20'd3, 20'd4, 20'd11, 16'h1234);
    insert_tri(20'd3, 20'd2, 20'd4, 20'd12, 16'hA5A5);
    insert_tri(20'd4, 20'd3, 20'd2, 20'd13, 16'h1234);
    insert_tri(20'd2, 20'd4, 20'd3, 20'd14, 16'h0000);
    lookup_tri(20'd1, 20'd1, 22'd3);
    lookup_tri(20'd1, 20'd1, 22'd3);
    lookup_tri(20'd2, 20'd4, 22'd9);
    lookup_tri(20'd2, 20'd4, 22'd9);
    lookup_tri(20'd5, 20'd7, 22'd18);
    lookup_tri(20'hFFFFF, 20'hFFFFF, 22'd3145725);
    insert_tri(20'd1, 20'd2, 20'hFFFFF, 20'h80000, 16'hA5A5);
    lookup_tri(20'd1, 20'hFFFFF, 22'd1048578);
    lookup_tri(20'd1, 20'hFFFFF, 22'd1048579);
    clear_table();
    lookup_tri(20'd2, 20'd4, 22'd9);

    setup(4095, 4096, 4, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    random_words(120);
    setup(1, 8, 1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    random_words(40);
    setup(37, 4096, 2, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    random_words(120);
    setup(200, 230, 3, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    random_words(120);
    setup(64, 4096, 4, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    random_words(80);
    setup(1024, 1, 0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    random_words(30);

    wait_idle();
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/tkh_pkg.sv
src/tkh_ctrl.sv
src/tkh_datapath.sv
src/triangle_key_hash_table_unit.sv
tb/tkh_checker.sv
tb/tb_triangle_key_hash_table_unit.sv
